// ===== src/oled_pfs_pkg.sv =====
// Shared types and constants of the OLED page frame streamer.
// Holds the controller command codes, register indexes and the queue item type.
// Depends on nothing; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package oled_pfs_pkg;

    localparam int PAGE_BYTES_DEFAULT  = 128;
    localparam int PAGE_COUNT_DEFAULT  = 8;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_OFFSET  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DISPLAY_ENABLE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONTRAST_LEVEL = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHUNK_MODE     = 2'd3;

    localparam logic [3:0] RST_COLUMN_OFFSET  = 4'd0;
    localparam logic       RST_DISPLAY_ENABLE = 1'b1;
    localparam logic [7:0] RST_CONTRAST_LEVEL = 8'd127;
    localparam logic       RST_CHUNK_MODE     = 1'b0;

    localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
    localparam logic [7:0] CMD_COL_LOW   = 8'h00;
    localparam logic [7:0] CMD_PAGE      = 8'hB0;
    localparam logic [7:0] CMD_ON        = 8'hAF;
    localparam logic [7:0] CMD_OFF       = 8'hAE;
    localparam logic [7:0] CMD_CONTRAST  = 8'h81;
    localparam logic [7:0] NIBBLE_MASK   = 8'h0F;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       frame_start;
        logic       chunk_start;
        logic       display_enable;
        logic [7:0] contrast_level;
        logic [7:0] column;
        logic [7:0] page;
        logic       chunk_done;
        logic       frame_done;
    } t_item;

endpackage

`default_nettype wire

// ===== src/oled_pfs_front.sv =====
// Front end: configuration registers, frame position counters and request classification.
// Builds one queue item per accepted request; uses oled_pfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module oled_pfs_front #(
    parameter int PAGE_BYTES = oled_pfs_pkg::PAGE_BYTES_DEFAULT,
    parameter int PAGE_COUNT = oled_pfs_pkg::PAGE_COUNT_DEFAULT
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [oled_pfs_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [oled_pfs_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [7:0]                          i_pixel_byte,
    input  wire logic                                i_restart_frame,
    input  wire logic                                i_queue_full,
    output logic                                     o_push,
    output oled_pfs_pkg::t_item                      o_item
);

    localparam int QUARTER = PAGE_BYTES / 4;
    localparam int COL_W   = $clog2(PAGE_BYTES);
    localparam int SUB_W   = $clog2(QUARTER);
    localparam int PAGE_W  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

    logic [3:0]        r_column_offset;
    logic              r_display_enable;
    logic [7:0]        r_contrast_level;
    logic              r_chunk_mode;

    logic [COL_W-1:0]  r_col, n_col, e_col;
    logic [SUB_W-1:0]  r_sub, n_sub, e_sub;
    logic [PAGE_W-1:0] r_page, n_page, e_page;

    logic last_col, last_sub, last_page, frame_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_offset  <= oled_pfs_pkg::RST_COLUMN_OFFSET;
            r_display_enable <= oled_pfs_pkg::RST_DISPLAY_ENABLE;
            r_contrast_level <= oled_pfs_pkg::RST_CONTRAST_LEVEL;
            r_chunk_mode     <= oled_pfs_pkg::RST_CHUNK_MODE;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                oled_pfs_pkg::CFG_COLUMN_OFFSET:  r_column_offset  <= i_cfg_wdata[3:0];
                oled_pfs_pkg::CFG_DISPLAY_ENABLE: r_display_enable <= i_cfg_wdata[0];
                oled_pfs_pkg::CFG_CONTRAST_LEVEL: r_contrast_level <= i_cfg_wdata[7:0];
                oled_pfs_pkg::CFG_CHUNK_MODE:     r_chunk_mode     <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_ready = !i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;

    always_comb begin
        e_col  = i_restart_frame ? '0 : r_col;
        e_sub  = i_restart_frame ? '0 : r_sub;
        e_page = i_restart_frame ? '0 : r_page;

        last_col   = (e_col == COL_W'(PAGE_BYTES - 1));
        last_sub   = (e_sub == SUB_W'(QUARTER - 1));
        last_page  = (e_page == PAGE_W'(PAGE_COUNT - 1));
        frame_done = last_col && last_page;

        if (frame_done) begin
            n_col  = '0;
            n_sub  = '0;
            n_page = '0;
        end else begin
            n_col  = last_col ? '0 : e_col + COL_W'(1);
            n_page = last_col ? e_page + PAGE_W'(1) : e_page;
            n_sub  = last_sub ? '0 : e_sub + SUB_W'(1);
        end

        o_item.pixel_byte     = i_pixel_byte;
        o_item.frame_start    = (e_col == '0) && (e_page == '0);
        o_item.chunk_start    = r_chunk_mode ? (e_sub == '0) : (e_col == '0);
        o_item.display_enable = r_display_enable;
        o_item.contrast_level = r_contrast_level;
        o_item.column         = 8'(r_column_offset) + 8'(e_col);
        o_item.page           = oled_pfs_pkg::CMD_PAGE | 8'(e_page);
        o_item.chunk_done     = frame_done || (r_chunk_mode ? last_sub : last_col);
        o_item.frame_done     = frame_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_sub  <= '0;
            r_page <= '0;
        end else if (o_push) begin
            r_col  <= n_col;
            r_sub  <= n_sub;
            r_page <= n_page;
        end
    end

endmodule

`default_nettype wire

// ===== src/oled_pfs_queue.sv =====
// Short register queue of classified items between the front and back ends.
// Item type comes from oled_pfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module oled_pfs_queue #(
    parameter int DEPTH = oled_pfs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire oled_pfs_pkg::t_item  i_data,
    output logic                      o_full,
    input  wire logic                 i_pop,
    output oled_pfs_pkg::t_item       o_data,
    output logic                      o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    oled_pfs_pkg::t_item r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]    r_count;

    function automatic logic [PTR_W-1:0] f_next(input logic [PTR_W-1:0] ptr);
        f_next = (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
    endfunction

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= f_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= f_next(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/oled_pfs_back.sv =====
// Back end: sequencer that expands one queued item into command and data bytes.
// Drives the registered output channel; uses oled_pfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module oled_pfs_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire oled_pfs_pkg::t_item  i_item,
    input  wire logic                 i_empty,
    output logic                      o_pop,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [7:0]                o_spi_byte,
    output logic                      o_data_not_command,
    output logic                      o_chunk_done,
    output logic                      o_frame_done,
    output logic                      o_last_of_run
);

    typedef enum logic [2:0] {
        STEP_ONOFF,
        STEP_CONTRAST_CMD,
        STEP_CONTRAST_VAL,
        STEP_COL_HIGH,
        STEP_COL_LOW,
        STEP_PAGE,
        STEP_DATA
    } t_step;

    t_step      r_step, cur_step, n_step;
    logic       r_mid;
    logic       load;
    logic [7:0] n_byte;

    always_comb begin
        if (r_mid) begin
            cur_step = r_step;
        end else if (i_item.frame_start) begin
            cur_step = STEP_ONOFF;
        end else if (i_item.chunk_start) begin
            cur_step = STEP_COL_HIGH;
        end else begin
            cur_step = STEP_DATA;
        end

        n_step = STEP_DATA;
        n_byte = i_item.pixel_byte;
        unique case (cur_step)
            STEP_ONOFF: begin
                n_byte = i_item.display_enable ? oled_pfs_pkg::CMD_ON : oled_pfs_pkg::CMD_OFF;
                n_step = STEP_CONTRAST_CMD;
            end
            STEP_CONTRAST_CMD: begin
                n_byte = oled_pfs_pkg::CMD_CONTRAST;
                n_step = STEP_CONTRAST_VAL;
            end
            STEP_CONTRAST_VAL: begin
                n_byte = i_item.contrast_level;
                n_step = STEP_COL_HIGH;
            end
            STEP_COL_HIGH: begin
                n_byte = oled_pfs_pkg::CMD_COL_HIGH | {4'd0, i_item.column[7:4]};
                n_step = STEP_COL_LOW;
            end
            STEP_COL_LOW: begin
                n_byte = oled_pfs_pkg::CMD_COL_LOW | (i_item.column & oled_pfs_pkg::NIBBLE_MASK);
                n_step = STEP_PAGE;
            end
            STEP_PAGE: begin
                n_byte = i_item.page;
                n_step = STEP_DATA;
            end
            STEP_DATA: begin
                n_byte = i_item.pixel_byte;
                n_step = STEP_DATA;
            end
            default: begin
                n_byte = i_item.pixel_byte;
                n_step = STEP_DATA;
            end
        endcase
    end

    assign load  = !i_empty && (!o_out_valid || i_out_ready);
    assign o_pop = load && (cur_step == STEP_DATA);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
            r_mid       <= 1'b0;
            r_step      <= STEP_DATA;
        end else if (load) begin
            o_out_valid <= 1'b1;
            r_mid       <= (cur_step != STEP_DATA);
            r_step      <= n_step;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_spi_byte         <= n_byte;
            o_data_not_command <= (cur_step == STEP_DATA);
            o_chunk_done       <= (cur_step == STEP_DATA) && i_item.chunk_done;
            o_frame_done       <= (cur_step == STEP_DATA) && i_item.frame_done;
            o_last_of_run      <= (cur_step == STEP_DATA);
        end
    end

endmodule

`default_nettype wire

// ===== src/oled_page_frame_streamer.sv =====
// Top level of the OLED page frame streamer: front end, item queue and back end.
// Depends on oled_pfs_pkg, oled_pfs_front, oled_pfs_queue and oled_pfs_back.
// An accepted request enters the item queue; the back-end sequencer registers its bytes.
// Throughput: one output byte per cycle while the output is ready; a request gives one
// data byte, after three command bytes at a chunk start and six at a frame start.
// Reset clears the frame position and the queue and loads the register reset values.
`timescale 1ns / 1ps
`default_nettype none

module oled_page_frame_streamer #(
    parameter int PAGE_BYTES  = oled_pfs_pkg::PAGE_BYTES_DEFAULT,
    parameter int PAGE_COUNT  = oled_pfs_pkg::PAGE_COUNT_DEFAULT,
    parameter int QUEUE_DEPTH = oled_pfs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [oled_pfs_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [oled_pfs_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [7:0]                          i_pixel_byte,
    input  wire logic                                i_restart_frame,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [7:0]                               o_spi_byte,
    output logic                                     o_data_not_command,
    output logic                                     o_chunk_done,
    output logic                                     o_frame_done,
    output logic                                     o_last_of_run
);

    oled_pfs_pkg::t_item push_item, head_item;
    logic                push, pop, full, empty;

    oled_pfs_front #(
        .PAGE_BYTES (PAGE_BYTES),
        .PAGE_COUNT (PAGE_COUNT)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_pixel_byte    (i_pixel_byte),
        .i_restart_frame (i_restart_frame),
        .i_queue_full    (full),
        .o_push          (push),
        .o_item          (push_item)
    );

    oled_pfs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (head_item),
        .o_empty (empty)
    );

    oled_pfs_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_item             (head_item),
        .i_empty            (empty),
        .o_pop              (pop),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_spi_byte         (o_spi_byte),
        .o_data_not_command (o_data_not_command),
        .o_chunk_done       (o_chunk_done),
        .o_frame_done       (o_frame_done),
        .o_last_of_run      (o_last_of_run)
    );

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for oled_page_frame_streamer.
// Predicts the command and data byte stream of every pixel request and checks it
// in order; depends on oled_pfs_pkg and the streamer RTL only.
`timescale 1ns / 1ps

module tb;

    localparam int PAGE_BYTES   = oled_pfs_pkg::PAGE_BYTES_DEFAULT;
    localparam int PAGE_COUNT   = oled_pfs_pkg::PAGE_COUNT_DEFAULT;
    localparam int FRAME_BYTES  = PAGE_BYTES * PAGE_COUNT;
    localparam int WALK_BYTES   = PAGE_BYTES + PAGE_BYTES / 4;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [7:0] spi_byte;
        logic       data_not_command;
        logic       chunk_done;
        logic       frame_done;
        logic       last_of_run;
    } t_beat;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_cfg_wr_en = 1'b0;
    logic [oled_pfs_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [oled_pfs_pkg::CFG_DATA_W-1:0]  i_cfg_wdata = '0;
    logic                                 i_in_valid = 1'b0;
    logic                                 o_in_ready;
    logic [7:0]                           i_pixel_byte = '0;
    logic                                 i_restart_frame = 1'b0;
    logic                                 o_out_valid;
    logic                                 i_out_ready = 1'b0;
    logic [7:0]                           o_spi_byte;
    logic                                 o_data_not_command;
    logic                                 o_chunk_done;
    logic                                 o_frame_done;
    logic                                 o_last_of_run;

    t_beat      pending_beats[$];
    int         frame_pos = 0;
    logic [3:0] shadow_offset = oled_pfs_pkg::RST_COLUMN_OFFSET;
    logic       shadow_enable = oled_pfs_pkg::RST_DISPLAY_ENABLE;
    logic [7:0] shadow_contrast = oled_pfs_pkg::RST_CONTRAST_LEVEL;
    logic       shadow_mode = oled_pfs_pkg::RST_CHUNK_MODE;
    int         error_count = 0;
    int         cycle_count = 0;
    int         next_gap = 0;
    int         ready_hold = 0;
    int         ready_gap;
    bit         gaps_on = 1'b1;

    oled_page_frame_streamer u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_pixel_byte       (i_pixel_byte),
        .i_restart_frame    (i_restart_frame),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_spi_byte         (o_spi_byte),
        .o_data_not_command (o_data_not_command),
        .o_chunk_done       (o_chunk_done),
        .o_frame_done       (o_frame_done),
        .o_last_of_run      (o_last_of_run)
    );

    always #2 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        if (!gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    function automatic void push_beat(input logic [7:0] b, input logic dnc,
                                      input logic cd, input logic fd, input logic last);
        t_beat beat;
        beat.spi_byte         = b;
        beat.data_not_command = dnc;
        beat.chunk_done       = cd;
        beat.frame_done       = fd;
        beat.last_of_run      = last;
        pending_beats.push_back(beat);
    endfunction

    function automatic void predict_stream(input logic [7:0] pix, input logic restart);
        int         span;
        int         pos;
        logic [7:0] col;
        logic [7:0] page;
        logic       fd;
        logic       cd;
        span = shadow_mode ? PAGE_BYTES / 4 : PAGE_BYTES;
        if (span == 0) span = 1;
        if (restart || frame_pos >= FRAME_BYTES) frame_pos = 0;
        pos = frame_pos;
        if (pos % span == 0) begin
            if (pos == 0) begin
                push_beat(shadow_enable ? oled_pfs_pkg::CMD_ON : oled_pfs_pkg::CMD_OFF,
                          1'b0, 1'b0, 1'b0, 1'b0);
                push_beat(oled_pfs_pkg::CMD_CONTRAST, 1'b0, 1'b0, 1'b0, 1'b0);
                push_beat(shadow_contrast, 1'b0, 1'b0, 1'b0, 1'b0);
            end
            col  = 8'(int'(shadow_offset) + pos % PAGE_BYTES);
            page = 8'(pos / PAGE_BYTES);
            push_beat(oled_pfs_pkg::CMD_COL_HIGH | {4'h0, col[7:4]}, 1'b0, 1'b0, 1'b0, 1'b0);
            push_beat(oled_pfs_pkg::CMD_COL_LOW | (col & oled_pfs_pkg::NIBBLE_MASK),
                      1'b0, 1'b0, 1'b0, 1'b0);
            push_beat(oled_pfs_pkg::CMD_PAGE | page, 1'b0, 1'b0, 1'b0, 1'b0);
        end
        pos++;
        fd = (pos >= FRAME_BYTES);
        cd = fd || (pos % span == 0);
        push_beat(pix, 1'b1, cd, fd, 1'b1);
        frame_pos = fd ? 0 : pos;
    endfunction

    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold  <= ready_hold - 1;
            i_out_ready <= 1'b0;
        end else begin
            ready_gap = pick_gap();
            ready_hold  <= ready_gap;
            i_out_ready <= (ready_gap == 0);
        end
    end

    always @(posedge i_clk) begin
        t_beat got;
        t_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_spi_byte, o_data_not_command, o_chunk_done, o_frame_done,
                   o_last_of_run};
            if (pending_beats.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_MAX)
                    $display("unexpected output byte %h dnc %b cd %b fd %b last %b",
                             got.spi_byte, got.data_not_command, got.chunk_done,
                             got.frame_done, got.last_of_run);
            end else begin
                want = pending_beats.pop_front();
                if (got.spi_byte !== want.spi_byte
                        || got.data_not_command !== want.data_not_command
                        || got.chunk_done !== want.chunk_done
                        || got.frame_done !== want.frame_done
                        || got.last_of_run !== want.last_of_run) begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                        $display("byte exp %h/%b%b%b%b got %h/%b%b%b%b (dnc cd fd last)",
                                 want.spi_byte, want.data_not_command, want.chunk_done,
                                 want.frame_done, want.last_of_run, got.spi_byte,
                                 got.data_not_command, got.chunk_done, got.frame_done,
                                 got.last_of_run);
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("oled_page_frame_streamer: mismatch");
        $finish;
    end

    task automatic hold_input();
        if (next_gap == 0) begin
            i_in_valid <= 1'b0;
            next_gap = 1;
        end
    endtask

    task automatic send_pixel(input logic [7:0] pix, input logic restart);
        repeat (next_gap) @(posedge i_clk);
        i_in_valid      <= 1'b1;
        i_pixel_byte    <= pix;
        i_restart_frame <= restart;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_stream(pix, restart);
        next_gap = pick_gap();
        if (next_gap != 0) i_in_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        hold_input();
        @(posedge i_clk);
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [3:0] offset, input logic enable,
                             input logic [7:0] contrast, input logic mode);
        wait_idle();
        shadow_offset   = offset;
        shadow_enable   = enable;
        shadow_contrast = contrast;
        shadow_mode     = mode;
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= oled_pfs_pkg::CFG_COLUMN_OFFSET;
        i_cfg_wdata <= {4'($urandom), offset};
        @(posedge i_clk);
        i_cfg_index <= oled_pfs_pkg::CFG_DISPLAY_ENABLE;
        i_cfg_wdata <= {7'($urandom), enable};
        @(posedge i_clk);
        i_cfg_index <= oled_pfs_pkg::CFG_CONTRAST_LEVEL;
        i_cfg_wdata <= contrast;
        @(posedge i_clk);
        i_cfg_index <= oled_pfs_pkg::CFG_CHUNK_MODE;
        i_cfg_wdata <= {7'($urandom), mode};
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic write_random_cfg();
        logic [3:0] offset;
        logic [7:0] contrast;
        case ($urandom_range(0, 2))
            0: offset = 4'd0;
            1: offset = 4'd15;
            default: offset = 4'($urandom);
        endcase
        case ($urandom_range(0, 2))
            0: contrast = 8'd0;
            1: contrast = 8'd255;
            default: contrast = 8'($urandom);
        endcase
        write_cfg(offset, 1'($urandom), contrast, 1'($urandom));
    endtask

    task automatic test_frame_start();
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h5A, 1'b1);
        send_pixel(8'hA5, 1'b0);
    endtask

    task automatic test_register_extremes();
        write_cfg(4'd15, 1'b0, 8'd0, 1'b1);
        send_pixel(8'hFF, 1'b1);
        send_pixel(8'h01, 1'b0);
        write_cfg(4'd0, 1'b1, 8'd255, 1'b0);
        send_pixel(8'h80, 1'b1);
        send_pixel(8'h7F, 1'b0);
        write_cfg(4'd15, 1'b1, 8'd255, 1'b1);
        send_pixel(8'h00, 1'b1);
        send_pixel(8'hC3, 1'b0);
    endtask

    // Walks past the first page boundary so both chunk sizes and the next page
    // are reached; the chunk mode changes at random points along the way.
    task automatic test_full_frame_walk();
        int sent;
        int seg;
        sent = 0;
        write_random_cfg();
        while (sent < WALK_BYTES) begin
            seg = $urandom_range(16, 48);
            if (seg > WALK_BYTES - sent) seg = WALK_BYTES - sent;
            gaps_on = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < seg; i++) begin
                send_pixel(8'($urandom), (sent == 0));
                sent++;
            end
            write_random_cfg();
        end
        gaps_on = 1'b1;
        send_pixel(8'($urandom), 1'b0);
        send_pixel(8'($urandom), 1'b0);
    endtask

    task automatic test_random_stream();
        int sent;
        int burst;
        sent = 0;
        while (sent < 50) begin
            if ($urandom_range(0, 1) == 0) write_random_cfg();
            else if ($urandom_range(0, 3) == 0) wait_idle();
            gaps_on = ($urandom_range(0, 4) != 0);
            burst = $urandom_range(5, 20);
            for (int i = 0; i < burst; i++) begin
                send_pixel(8'($urandom), ($urandom_range(0, 15) == 0));
                sent++;
            end
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_frame_start();
        test_register_extremes();
        test_full_frame_walk();
        test_random_stream();
        wait_idle();
        if (error_count == 0) begin
            $display("oled_page_frame_streamer: match");
        end else begin
            $display("oled_page_frame_streamer: mismatch");
        end
        $finish;
    end

endmodule

// ===== oled_page_frame_streamer.f =====
src/oled_pfs_pkg.sv
src/oled_pfs_front.sv
src/oled_pfs_queue.sv
src/oled_pfs_back.sv
src/oled_page_frame_streamer.sv
sim/tb.sv
